// ===== sv/mlfq_pkg.sv =====
// Package for the MLFQ ready-queue scheduler.
// Holds operation codes, status codes, controller states and the
// controller/datapath command and status structs. No dependencies.
package mlfq_pkg;

	typedef enum logic [2:0] {
		OP_SET_PRI  = 3'd0,
		OP_ENQUEUE  = 3'd1,
		OP_DEQUEUE  = 3'd2,
		OP_DETACH   = 3'd3,
		OP_SWITCH   = 3'd4,
		OP_RESTED   = 3'd5,
		OP_SLEEP    = 3'd6,
		OP_RSVD     = 3'd7
	} op_t;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NONE       = 2'd1;
	localparam logic [1:0] ST_NOT_QUEUED = 2'd2;
	localparam logic [1:0] ST_ALREADY    = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EXEC,
		S_LINK,
		S_SHEAD,
		S_SCHK,
		S_SNEXT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;       // latch transaction, cur = thread_id, level = 0
		logic exec;       // apply the operation, capture the result
		logic link2;      // second half of a tail append
		logic lvl_inc;    // scan moves to the next level
		logic scan_head;  // cur = head of scan level
		logic scan_next;  // cur = next link of cur
		logic none_res;   // capture the nothing-runnable result
	} cmd_t;

	typedef struct packed {
		logic is_deq;
		logic link_need;
		logic head_nil;
		logic last_lvl;
		logic cur_sleep;
		logic nxt_nil;
	} sts_t;

endpackage

// ===== sv/mlfq_ready_queue_scheduler_core.sv =====
// Top level of the MLFQ ready-queue scheduler.
// Instantiates mlfq_ctrl and mlfq_dp; depends on mlfq_pkg.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low;
//   operation, thread_id, new_priority and sleep_value are sampled there.
//   Exactly one result follows: done is high for one cycle and
//   result_thread, found, result_priority and status are valid in that cycle.
//   The receiver cannot stall; results are taken in the done cycle.
// Sequence after acceptance:
//   S_RD reads the thread's link, priority and level memories; non-dequeue
//   operations then apply in S_EXEC, enqueue adding the tail link in S_LINK;
//   dequeue scans levels from 0 (S_SHEAD), walking past sleeping threads
//   (S_SCHK, S_SNEXT) to the first runnable one or reports nothing runnable.
//   One transaction at a time: busy stays high until the cycle after done.
//   The dequeue walk is set by the one-read-per-cycle next-link memory,
//   whose read data is registered.
// Reset (arst_n low): all queues empty, all priorities, rested, sleep and
//   queued marks zero; link memories are written before they are read.
module mlfq_ready_queue_scheduler_core #(
	parameter int NUM_QUEUES  = 8,
	parameter int MAX_THREADS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	input  logic [2:0] operation,
	input  logic [5:0] thread_id,
	input  logic [2:0] new_priority,
	input  logic       sleep_value,
	output logic [5:0] result_thread,
	output logic       found,
	output logic [2:0] result_priority,
	output logic [1:0] status
);
	import mlfq_pkg::*;

	cmd_t cmd;  // controller -> datapath
	sts_t sts;  // datapath -> controller

	mlfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mlfq_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.MAX_THREADS (MAX_THREADS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.thread_id       (thread_id),
		.new_priority    (new_priority),
		.sleep_value     (sleep_value),
		.result_thread   (result_thread),
		.found           (found),
		.result_priority (result_priority),
		.status          (status)
	);

endmodule

// ===== sv/mlfq_ctrl.sv =====
// Controller state machine of the MLFQ scheduler.
// Depends on mlfq_pkg; drives the datapath by cmd_t, reads sts_t.
module mlfq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mlfq_pkg::sts_t sts,
	output mlfq_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import mlfq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				state_d = sts.is_deq ? S_SHEAD : S_EXEC;
			end
			S_SHEAD: begin
				if (sts.head_nil) begin
					if (sts.last_lvl) begin
						cmd.none_res = 1'b1;
						state_d      = S_DONE;
					end else begin
						cmd.lvl_inc = 1'b1;
					end
				end else begin
					cmd.scan_head = 1'b1;
					state_d       = S_SCHK;
				end
			end
			S_SCHK: begin
				state_d = sts.cur_sleep ? S_SNEXT : S_EXEC;
			end
			S_SNEXT: begin
				if (sts.nxt_nil) begin
					if (sts.last_lvl) begin
						cmd.none_res = 1'b1;
						state_d      = S_DONE;
					end else begin
						cmd.lvl_inc = 1'b1;
						state_d     = S_SHEAD;
					end
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCHK;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.link_need ? S_LINK : S_DONE;
			end
			S_LINK: begin
				cmd.link2 = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/mlfq_dp.sv =====
// Datapath of the MLFQ scheduler: queue heads/tails, per-thread flags,
// link/priority/level memories and result registers. Depends on mlfq_pkg.
module mlfq_dp #(
	parameter int NUM_QUEUES  = 8,
	parameter int MAX_THREADS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mlfq_pkg::cmd_t cmd,
	output mlfq_pkg::sts_t sts,
	input  logic [2:0]     operation,
	input  logic [5:0]     thread_id,
	input  logic [2:0]     new_priority,
	input  logic           sleep_value,
	output logic [5:0]     result_thread,
	output logic           found,
	output logic [2:0]     result_priority,
	output logic [1:0]     status
);
	import mlfq_pkg::*;

	localparam int SW = $clog2(MAX_THREADS);
	localparam int TW = $clog2(MAX_THREADS + 1);
	localparam int QW = $clog2(NUM_QUEUES);
	localparam logic [TW-1:0] NIL      = TW'(MAX_THREADS);
	localparam logic [QW-1:0] LAST_LVL = QW'(NUM_QUEUES - 1);

	op_t           op_q;
	logic [5:0]    t_q;
	logic [2:0]    np_q;
	logic          sv_q;
	logic [TW-1:0] cur_q;
	logic [QW-1:0] lvl_q;

	logic [TW-1:0] head_q [NUM_QUEUES];
	logic [TW-1:0] tail_q [NUM_QUEUES];
	logic [MAX_THREADS-1:0] queued_q, sleep_q, rested_q, pvld_q;

	logic [TW-1:0] nxt_mem [MAX_THREADS];
	logic [TW-1:0] prv_mem [MAX_THREADS];
	logic [QW-1:0] pri_mem [MAX_THREADS];
	logic [QW-1:0] qlv_mem [MAX_THREADS];
	logic [TW-1:0] nxt_rd_q, prv_rd_q;
	logic [QW-1:0] pri_rd_q, qlv_rd_q;

	logic [5:0] res_t_q;
	logic       found_q;
	logic [2:0] res_p_q;
	logic [1:0] status_q;

	logic [SW-1:0] cidx;
	logic          t_valid, is_deq, do_unlink, do_link1, do_setp, do_switch;
	logic [QW-1:0] pri_cur, np_sat, pri_sw, pri_new, link_lvl;
	logic [TW-1:0] last_w;
	logic [31:0]   cur_w, pri_new_w, pri_cur_w;

	logic          nxt_we, prv_we;
	logic [SW-1:0] nxt_wa, prv_wa;
	logic [TW-1:0] nxt_wd, prv_wd;

	assign cidx    = cur_q[SW-1:0];
	assign t_valid = 32'(t_q) < MAX_THREADS;
	assign is_deq  = (op_q == OP_DEQUEUE);
	assign pri_cur = pvld_q[cidx] ? pri_rd_q : '0;
	assign np_sat  = (32'(np_q) >= NUM_QUEUES) ? LAST_LVL : QW'(np_q);

	always_comb begin
		if (rested_q[cidx]) begin
			pri_sw = (pri_cur != '0) ? pri_cur - QW'(1) : pri_cur;
		end else begin
			pri_sw = (pri_cur < LAST_LVL) ? pri_cur + QW'(1) : pri_cur;
		end
	end

	assign do_unlink = is_deq || (op_q == OP_DETACH && t_valid && queued_q[cidx]);
	assign do_link1  = op_q == OP_ENQUEUE && t_valid && !queued_q[cidx];
	assign do_setp   = op_q == OP_SET_PRI && t_valid;
	assign do_switch = op_q == OP_SWITCH && t_valid && t_q != 6'd0;
	assign pri_new   = do_setp ? np_sat : (do_switch ? pri_sw : pri_cur);
	assign link_lvl  = pri_cur;
	assign last_w    = tail_q[link_lvl];

	assign cur_w     = 32'(cur_q);
	assign pri_new_w = 32'(pri_new);
	assign pri_cur_w = 32'(pri_cur);

	assign sts.is_deq    = is_deq;
	assign sts.link_need = do_link1;
	assign sts.head_nil  = head_q[lvl_q] == NIL;
	assign sts.last_lvl  = lvl_q == LAST_LVL;
	assign sts.cur_sleep = sleep_q[cidx];
	assign sts.nxt_nil   = nxt_rd_q == NIL;

	// link memory write ports
	always_comb begin
		nxt_we = 1'b0;
		nxt_wa = '0;
		nxt_wd = '0;
		prv_we = 1'b0;
		prv_wa = '0;
		prv_wd = '0;
		if (cmd.exec && do_unlink) begin
			nxt_we = prv_rd_q != NIL;
			nxt_wa = prv_rd_q[SW-1:0];
			nxt_wd = nxt_rd_q;
			prv_we = nxt_rd_q != NIL;
			prv_wa = nxt_rd_q[SW-1:0];
			prv_wd = prv_rd_q;
		end else if (cmd.exec && do_link1) begin
			nxt_we = 1'b1;
			nxt_wa = cidx;
			nxt_wd = NIL;
			prv_we = 1'b1;
			prv_wa = cidx;
			prv_wd = last_w;
		end else if (cmd.link2) begin
			nxt_we = last_w != NIL;
			nxt_wa = last_w[SW-1:0];
			nxt_wd = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_wa] <= nxt_wd;
		end
		if (prv_we) begin
			prv_mem[prv_wa] <= prv_wd;
		end
		if (cmd.exec && (do_setp || do_switch)) begin
			pri_mem[cidx] <= pri_new;
		end
		if (cmd.exec && do_link1) begin
			qlv_mem[cidx] <= link_lvl;
		end
		nxt_rd_q <= nxt_mem[cidx];
		prv_rd_q <= prv_mem[cidx];
		pri_rd_q <= pri_mem[cidx];
		qlv_rd_q <= qlv_mem[cidx];
	end

	// transaction and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(operation);
			t_q   <= thread_id;
			np_q  <= new_priority;
			sv_q  <= sleep_value;
			cur_q <= TW'(thread_id);
			lvl_q <= '0;
		end
		if (cmd.lvl_inc) begin
			lvl_q <= lvl_q + QW'(1);
		end
		if (cmd.scan_head) begin
			cur_q <= head_q[lvl_q];
		end
		if (cmd.scan_next) begin
			cur_q <= nxt_rd_q;
		end
	end

	// queue ends and per-thread flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
			queued_q <= '0;
			sleep_q  <= '0;
			rested_q <= '0;
			pvld_q   <= '0;
		end else begin
			if (cmd.exec) begin
				if (do_unlink) begin
					if (prv_rd_q == NIL) begin
						head_q[qlv_rd_q] <= nxt_rd_q;
					end
					if (nxt_rd_q == NIL) begin
						tail_q[qlv_rd_q] <= prv_rd_q;
					end
					queued_q[cidx] <= 1'b0;
				end
				if (do_setp || do_switch) begin
					pvld_q[cidx] <= 1'b1;
				end
				if (do_switch) begin
					rested_q[cidx] <= 1'b0;
				end
				if (op_q == OP_RESTED && t_valid) begin
					rested_q[cidx] <= 1'b1;
				end
				if (op_q == OP_SLEEP && t_valid) begin
					sleep_q[cidx] <= sv_q;
				end
			end
			if (cmd.link2) begin
				if (last_w == NIL) begin
					head_q[link_lvl] <= cur_q;
				end
				tail_q[link_lvl] <= cur_q;
				queued_q[cidx]   <= 1'b1;
			end
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (cmd.none_res) begin
			res_t_q  <= '0;
			found_q  <= 1'b0;
			res_p_q  <= '0;
			status_q <= ST_NONE;
		end else if (cmd.exec) begin
			if (is_deq) begin
				res_t_q  <= cur_w[5:0];
				found_q  <= 1'b1;
				res_p_q  <= pri_cur_w[2:0];
				status_q <= ST_OK;
			end else begin
				res_t_q  <= t_q;
				found_q  <= 1'b0;
				res_p_q  <= t_valid ? pri_new_w[2:0] : 3'd0;
				if (t_valid && op_q == OP_ENQUEUE && queued_q[cidx]) begin
					status_q <= ST_ALREADY;
				end else if (t_valid && op_q == OP_DETACH && !queued_q[cidx]) begin
					status_q <= ST_NOT_QUEUED;
				end else begin
					status_q <= ST_OK;
				end
			end
		end
	end

	assign result_thread   = res_t_q;
	assign found           = found_q;
	assign result_priority = res_p_q;
	assign status          = status_q;

endmodule

// ===== sv/mlfq_chk.sv =====
// Port-level checker for the MLFQ scheduler core and its bind.
// Depends on mlfq_pkg and mlfq_ready_queue_scheduler_core.
module mlfq_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [5:0] result_thread,
	input logic       found,
	input logic [1:0] status
);
	import mlfq_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK)
		else $error("found with non-ok status");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NONE |-> !found && result_thread == 6'd0)
		else $error("nothing-runnable result not cleared");

endmodule

bind mlfq_ready_queue_scheduler_core mlfq_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.result_thread (result_thread),
	.found         (found),
	.status        (status)
);

// ===== tb/tb_top.sv =====
// Testbench for mlfq_ready_queue_scheduler_core: directed table, then random traffic,
// every result checked against an in-bench ready-queue predictor.
// Depends on mlfq_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
	import mlfq_pkg::*;

	localparam int NQ = 8;
	localparam int NT = 64;
	localparam int NIL = NT;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [2:0] operation = OP_SET_PRI;
	logic [5:0] thread_id = '0;
	logic [2:0] new_priority = '0;
	logic sleep_value = 1'b0;
	logic [5:0] result_thread;
	logic found;
	logic [2:0] result_priority;
	logic [1:0] status;

	mlfq_ready_queue_scheduler_core #(.NUM_QUEUES(NQ), .MAX_THREADS(NT)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.operation(operation), .thread_id(thread_id), .new_priority(new_priority),
		.sleep_value(sleep_value), .result_thread(result_thread), .found(found),
		.result_priority(result_priority), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		logic [5:0] thr;
		logic       fnd;
		logic [2:0] pri;
		logic [1:0] st;
	} sched_res_t;

	// Predictor state: linked ready queues over thread slots
	int unsigned head_q[NQ], tail_q[NQ];
	int unsigned nxt[NT], prv[NT];
	logic [2:0] pri_of[NT];
	bit rested[NT], asleep[NT], queued[NT];
	int unsigned qlvl[NT];

	sched_res_t pending_q[$];
	int errors = 0;
	int cycles = 0;
	int sender_idle_pct = 0;

	function automatic void append_thread(int unsigned t);
		int unsigned lvl;
		lvl = pri_of[t];
		prv[t] = tail_q[lvl];
		nxt[t] = NIL;
		if (tail_q[lvl] < NT) nxt[tail_q[lvl]] = t;
		else head_q[lvl] = t;
		tail_q[lvl] = t;
		qlvl[t] = lvl;
		queued[t] = 1;
	endfunction

	function automatic void remove_thread(int unsigned t);
		int unsigned lvl, p, n;
		lvl = qlvl[t];
		p = prv[t];
		n = nxt[t];
		if (p < NT) nxt[p] = n;
		else head_q[lvl] = n;
		if (n < NT) prv[n] = p;
		else tail_q[lvl] = p;
		nxt[t] = NIL;
		prv[t] = NIL;
		queued[t] = 0;
	endfunction

	function automatic sched_res_t schedule_op(op_t op, int unsigned t, logic [2:0] np,
			logic sv);
		sched_res_t r;
		int unsigned c;
		r.thr = 6'(t);
		r.fnd = 0;
		r.st = ST_OK;
		r.pri = 0;
		if (op == OP_DEQUEUE) begin
			r.thr = 0;
			r.st = ST_NONE;
			for (int lvl = 0; lvl < NQ && !r.fnd; lvl++) begin
				c = head_q[lvl];
				while (c < NT && asleep[c]) c = nxt[c];
				if (c < NT) begin
					remove_thread(c);
					r.thr = 6'(c);
					r.fnd = 1;
					r.st = ST_OK;
					r.pri = pri_of[c];
				end
			end
		end else begin
			case (op)
				OP_SET_PRI: pri_of[t] = np;
				OP_ENQUEUE: begin
					if (queued[t]) r.st = ST_ALREADY;
					else append_thread(t);
				end
				OP_DETACH: begin
					if (queued[t]) remove_thread(t);
					else r.st = ST_NOT_QUEUED;
				end
				OP_SWITCH: begin
					if (t != 0) begin
						if (rested[t]) begin
							rested[t] = 0;
							if (pri_of[t] > 0) pri_of[t]--;
						end else if (pri_of[t] < NQ - 1) pri_of[t]++;
					end
				end
				OP_RESTED: rested[t] = 1;
				OP_SLEEP: asleep[t] = sv;
				default: ;
			endcase
			r.pri = pri_of[t];
		end
		return r;
	endfunction

	// Result monitor: done marks one result cycle; receiver never stalls
	always @(posedge clk) begin
		sched_res_t e;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result transaction thread=%0d", result_thread);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (result_thread !== e.thr) begin
					$error("result_thread exp %0d got %0d", e.thr, result_thread);
					errors++;
				end
				if (found !== e.fnd) begin
					$error("found exp %0d got %0d", e.fnd, found);
					errors++;
				end
				if (result_priority !== e.pri) begin
					$error("result_priority exp %0d got %0d", e.pri, result_priority);
					errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	// Issue one transaction; a typed-in expectation, when given, must match the predictor.
	// busy is sampled at the falling edge, so the accepting rising edge is known exactly.
	task automatic issue_op(op_t op, logic [5:0] t, logic [2:0] np, logic sv,
			bit has_fixed, sched_res_t fixed);
		sched_res_t r;
		bit acc;
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		operation <= op;
		thread_id <= t;
		new_priority <= np;
		sleep_value <= sv;
		do begin
			@(negedge clk);
			acc = !busy;
			@(posedge clk);
		end while (!acc);
		r = schedule_op(op, t, np, sv);
		if (has_fixed && (r.thr != fixed.thr || r.fnd != fixed.fnd || r.pri != fixed.pri
				|| r.st != fixed.st)) begin
			$error("directed row disagrees with predictor, op %0d thread %0d", op, t);
			errors++;
		end
		pending_q.push_back(r);
	endtask

	typedef struct {
		op_t        op;
		logic [5:0] t;
		logic [2:0] np;
		logic       sv;
		bit         fixed;
		sched_res_t res;
	} dir_row_t;

	dir_row_t dir_tab[] = '{
		'{OP_DEQUEUE,  6'd0,  3'd0, 1'b0, 1, '{6'd0,  1'b0, 3'd0, ST_NONE}},
		'{OP_DETACH,   6'd63, 3'd0, 1'b0, 1, '{6'd63, 1'b0, 3'd0, ST_NOT_QUEUED}},
		'{OP_SET_PRI,  6'd63, 3'd7, 1'b1, 1, '{6'd63, 1'b0, 3'd7, ST_OK}},
		'{OP_ENQUEUE,  6'd63, 3'd0, 1'b0, 1, '{6'd63, 1'b0, 3'd7, ST_OK}},
		'{OP_ENQUEUE,  6'd63, 3'd0, 1'b0, 1, '{6'd63, 1'b0, 3'd7, ST_ALREADY}},
		'{OP_ENQUEUE,  6'd0,  3'd0, 1'b0, 1, '{6'd0,  1'b0, 3'd0, ST_OK}},
		'{OP_ENQUEUE,  6'd5,  3'd0, 1'b0, 0, '{default: 0}},
		'{OP_SLEEP,    6'd0,  3'd0, 1'b1, 0, '{default: 0}},
		'{OP_DEQUEUE,  6'd0,  3'd0, 1'b0, 0, '{default: 0}},
		'{OP_SWITCH,   6'd0,  3'd0, 1'b0, 1, '{6'd0,  1'b0, 3'd0, ST_OK}},
		'{OP_SWITCH,   6'd63, 3'd0, 1'b0, 1, '{6'd63, 1'b0, 3'd7, ST_OK}},
		'{OP_RESTED,   6'd63, 3'd0, 1'b0, 0, '{default: 0}},
		'{OP_SWITCH,   6'd63, 3'd0, 1'b0, 1, '{6'd63, 1'b0, 3'd6, ST_OK}},
		'{OP_SWITCH,   6'd5,  3'd0, 1'b0, 0, '{default: 0}},
		'{OP_RSVD,     6'd42, 3'd5, 1'b1, 1, '{6'd42, 1'b0, 3'd0, ST_OK}},
		'{OP_DEQUEUE,  6'd21, 3'd0, 1'b0, 0, '{default: 0}},
		'{OP_SLEEP,    6'd0,  3'd0, 1'b0, 0, '{default: 0}},
		'{OP_DETACH,   6'd0,  3'd0, 1'b0, 1, '{6'd0,  1'b0, 3'd0, ST_OK}},
		'{OP_DEQUEUE,  6'd0,  3'd0, 1'b0, 0, '{default: 0}},
		'{OP_DEQUEUE,  6'd0,  3'd0, 1'b0, 1, '{6'd0,  1'b0, 3'd0, ST_NONE}}
	};

	// Random traffic favors few threads so queues fill and dequeues find work
	task automatic random_burst(int n);
		op_t op;
		logic [5:0] t;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 25) op = OP_ENQUEUE;
			else if (k < 45) op = OP_DEQUEUE;
			else if (k < 55) op = OP_DETACH;
			else if (k < 67) op = OP_SET_PRI;
			else if (k < 77) op = OP_SWITCH;
			else if (k < 85) op = OP_RESTED;
			else if (k < 97) op = OP_SLEEP;
			else op = OP_RSVD;
			t = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
			issue_op(op, t, 3'($urandom), 1'($urandom_range(3) == 0), 0, '{default: 0});
		end
	endtask

	initial begin
		for (int i = 0; i < NQ; i++) begin
			head_q[i] = NIL;
			tail_q[i] = NIL;
		end
		for (int i = 0; i < NT; i++) begin
			nxt[i] = NIL;
			prv[i] = NIL;
			pri_of[i] = 0;
			rested[i] = 0;
			asleep[i] = 0;
			queued[i] = 0;
			qlvl[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			issue_op(dir_tab[i].op, dir_tab[i].t, dir_tab[i].np, dir_tab[i].sv,
				dir_tab[i].fixed, dir_tab[i].res);

		sender_idle_pct = 38;
		random_burst(200);
		// hold off until the block has drained every result
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		sender_idle_pct = 60;
		random_burst(200);
		sender_idle_pct = 0;
		random_burst(200);
		start <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end

	// Watchdog
	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

endmodule
